// ----- src/sctw_pkg.sv -----
// Shared types and constants for the sibling-chain trie walk unit.
package sctw_pkg;

  // Fixed field widths of the stream items
  localparam int unsigned IDX_W    = 13;
  localparam int unsigned CODE_W   = 16;
  localparam int unsigned GSTART_W = 16;
  localparam int unsigned GCOUNT_W = 16;
  localparam int unsigned RCOUNT_W = 17;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CNT_W    = 13;

  // Stream widths (tdata filled up to whole bytes)
  localparam int unsigned IN_TDATA_W  = 88;
  localparam int unsigned OUT_TDATA_W = 48;

  // Defaults for the top-level parameters
  localparam int unsigned NODES_DEF     = 4096;
  localparam int unsigned CODE_BITS_DEF = 16;

  // Group offsets are 16 bits wide, so with a group area of 64K entries the
  // offset reduction is the identity and needs no logic.
  localparam int unsigned GROUP_AREA = 65536;

  localparam logic [IDX_W-1:0]    IDX_NONE    = '1;
  localparam logic [RCOUNT_W-1:0] RCOUNT_NONE = '1;

  typedef enum logic [0:0] {
    KIND_WRITE  = 1'b0,
    KIND_LOOKUP = 1'b1
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND   = 2'd0,
    ST_MISS    = 2'd1,
    ST_OVERRUN = 2'd2
  } status_e;

  typedef struct packed {
    status_e               status;
    logic [IDX_W-1:0]      child_node;
    logic [GSTART_W-1:0]   found_group_start;
    logic [RCOUNT_W-1:0]   found_group_count;
  } result_t;

endpackage

// ----- src/sctw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module sctw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- src/sctw_walk.sv -----
// Walk sequencer: node writes, sibling-chain stepping with one shared compare.
module sctw_walk #(
  parameter int unsigned NODES     = sctw_pkg::NODES_DEF,
  parameter int unsigned CODE_BITS = sctw_pkg::CODE_BITS_DEF,
  localparam int unsigned CW = (CODE_BITS < sctw_pkg::CODE_W) ? CODE_BITS : sctw_pkg::CODE_W,
  localparam int unsigned EW = CW + 2 * sctw_pkg::IDX_W + sctw_pkg::GSTART_W
                               + sctw_pkg::GCOUNT_W,
  localparam int unsigned AW = $clog2(NODES)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  sctw_pkg::kind_e                 in_kind_i,
  input  logic [sctw_pkg::IDX_W-1:0]      in_index_i,
  input  logic [sctw_pkg::CODE_W-1:0]     in_code_i,
  input  logic [sctw_pkg::IDX_W-1:0]      in_next_i,
  input  logic [sctw_pkg::IDX_W-1:0]      in_child_i,
  input  logic [sctw_pkg::GSTART_W-1:0]   in_gstart_i,
  input  logic [sctw_pkg::GCOUNT_W-1:0]   in_gcount_i,
  input  logic [sctw_pkg::CNT_W-1:0]      node_count_i,
  input  logic                            out_free_i,
  output logic                            done_o,
  output sctw_pkg::result_t               result_o,
  output logic                            ram_we_o,
  output logic [AW-1:0]                   ram_waddr_o,
  output logic [EW-1:0]                   ram_wdata_o,
  output logic                            ram_re_o,
  output logic [AW-1:0]                   ram_raddr_o,
  input  logic [EW-1:0]                   ram_rdata_i
);

  localparam int unsigned SW = $clog2(NODES + 1);
  localparam int unsigned IW = sctw_pkg::IDX_W;

  // Field positions inside one table entry, code in the lowest bits
  localparam int unsigned NEXT_LO   = CW;
  localparam int unsigned CHILD_LO  = NEXT_LO + IW;
  localparam int unsigned GSTART_LO = CHILD_LO + IW;
  localparam int unsigned GCOUNT_LO = GSTART_LO + sctw_pkg::GSTART_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_CMP   = 4'b0100,
    S_RESP  = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     want_q, want_d;
  logic [SW-1:0]     steps_q, steps_d;
  sctw_pkg::result_t res_q, res_d;

  logic          accept;
  logic          idx_none;
  logic          idx_bad;
  logic          wr_in_range;
  logic [CW-1:0] rd_code;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  assign wr_in_range = !in_index_i[IW-1] && (32'(in_index_i[IW-2:0]) < NODES);
  assign ram_we_o    = accept && (in_kind_i == sctw_pkg::KIND_WRITE) && wr_in_range;
  assign ram_waddr_o = AW'(in_index_i[IW-2:0]);
  assign ram_wdata_o = {in_gcount_i, in_gstart_i, in_child_i, in_next_i, in_code_i[CW-1:0]};

  assign idx_none = (idx_q == sctw_pkg::IDX_NONE);
  assign idx_bad  = idx_q[IW-1]
                 || ({1'b0, idx_q[IW-2:0]} >= node_count_i)
                 || (32'(idx_q[IW-2:0]) >= NODES)
                 || (steps_q >= SW'(NODES));

  assign ram_re_o    = (state_q == S_CHECK) && !idx_none && !idx_bad;
  assign ram_raddr_o = AW'(idx_q[IW-2:0]);

  assign rd_code  = ram_rdata_i[CW-1:0];
  assign done_o   = (state_q == S_RESP) && out_free_i;
  assign result_o = res_q;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    want_d  = want_q;
    steps_d = steps_q;
    res_d   = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (in_kind_i == sctw_pkg::KIND_LOOKUP)) begin
          idx_d   = in_index_i;
          want_d  = in_code_i[CW-1:0];
          steps_d = '0;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (idx_none) begin
          res_d.status            = sctw_pkg::ST_MISS;
          res_d.child_node        = sctw_pkg::IDX_NONE;
          res_d.found_group_start = '0;
          res_d.found_group_count = sctw_pkg::RCOUNT_NONE;
          state_d = S_RESP;
        end else if (idx_bad) begin
          res_d.status            = sctw_pkg::ST_OVERRUN;
          res_d.child_node        = sctw_pkg::IDX_NONE;
          res_d.found_group_start = '0;
          res_d.found_group_count = sctw_pkg::RCOUNT_NONE;
          state_d = S_RESP;
        end else begin
          steps_d = steps_q + SW'(1);
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (rd_code == want_q) begin
          res_d.status            = sctw_pkg::ST_FOUND;
          res_d.child_node        = ram_rdata_i[CHILD_LO +: IW];
          res_d.found_group_start = ram_rdata_i[GSTART_LO +: sctw_pkg::GSTART_W];
          res_d.found_group_count = {1'b0, ram_rdata_i[GCOUNT_LO +: sctw_pkg::GCOUNT_W]};
          state_d = S_RESP;
        end else begin
          // advance along the sibling chain
          idx_d   = ram_rdata_i[NEXT_LO +: IW];
          state_d = S_CHECK;
        end
      end
      S_RESP: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    want_q  <= want_d;
    steps_q <= steps_d;
    res_q   <= res_d;
  end

endmodule

// ----- src/sibling_chain_trie_walk_unit.sv -----
// Top level of the sibling-chain trie walk unit: streams, config and result register.
// Write transaction: taken while idle, back to back; it gives no result. Lookup transaction: a
// check state issues the read of each visited node and a compare state follows; a match goes
// to the result state, a miss or overrun from the check state (at once when the start is -1).
// A result waits for the output register; a new transaction is taken the cycle after its load.
// Reset clears the sequencer, node_count and the output valid; the node table is not cleared.
module sibling_chain_trie_walk_unit #(
  parameter int unsigned NODES     = sctw_pkg::NODES_DEF,
  parameter int unsigned CODE_BITS = sctw_pkg::CODE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sctw_pkg::CNT_W-1:0]         cfg_wdata_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // node_index[12:0], code[28:13], next_sibling[41:29], first_child[54:42],
  // group_start[70:55], group_count[86:71], zero pad [87]
  input  logic [sctw_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  // kind[0]
  input  logic                               s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // child_node[12:0], found_group_start[28:13], found_group_count[45:29],
  // zero pad [47:46]
  output logic [sctw_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  // status[1:0]
  output logic [sctw_pkg::STATUS_W-1:0]      m_axis_tuser_o
);

  localparam int unsigned CW = (CODE_BITS < sctw_pkg::CODE_W) ? CODE_BITS : sctw_pkg::CODE_W;
  localparam int unsigned EW = CW + 2 * sctw_pkg::IDX_W + sctw_pkg::GSTART_W
                               + sctw_pkg::GCOUNT_W;
  localparam int unsigned AW = $clog2(NODES);

  logic [sctw_pkg::CNT_W-1:0] node_count_q;
  logic                       out_valid_q, out_valid_d;
  sctw_pkg::result_t          out_res_q;

  logic              out_free;
  logic              done;
  sctw_pkg::result_t walk_res;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [EW-1:0]     ram_wdata, ram_rdata;

  assign out_free    = !out_valid_q || m_axis_tready_i;
  // hold a waiting result until the transaction completes
  assign out_valid_d = done ? 1'b1 : (m_axis_tready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        node_count_q <= cfg_wdata_i;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_res_q <= walk_res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_res_q.status;
  assign m_axis_tdata_o  = {2'b00, out_res_q.found_group_count,
                            out_res_q.found_group_start, out_res_q.child_node};

  sctw_walk #(
    .NODES     (NODES),
    .CODE_BITS (CODE_BITS)
  ) u_walk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_kind_i    (sctw_pkg::kind_e'(s_axis_tuser_i)),
    .in_index_i   (s_axis_tdata_i[12:0]),
    .in_code_i    (s_axis_tdata_i[28:13]),
    .in_next_i    (s_axis_tdata_i[41:29]),
    .in_child_i   (s_axis_tdata_i[54:42]),
    .in_gstart_i  (s_axis_tdata_i[70:55]),
    .in_gcount_i  (s_axis_tdata_i[86:71]),
    .node_count_i (node_count_q),
    .out_free_i   (out_free),
    .done_o       (done),
    .result_o     (walk_res),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata)
  );

  sctw_ram #(
    .WIDTH (EW),
    .DEPTH (NODES)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// ----- verif/trie_walk_checker.sv -----
// Checker for the trie walk unit: mirrors the node table, predicts lookup results and compares.
module trie_walk_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sctw_pkg::CNT_W-1:0]        cfg_wdata_i,
  input  logic                              s_tvalid_i,
  input  logic                              s_tready_i,
  // node_index, code, next_sibling, first_child, group_start, group_count, pad
  input  logic [sctw_pkg::IN_TDATA_W-1:0]   s_tdata_i,
  // kind
  input  logic                              s_tuser_i,
  input  logic                              m_tvalid_i,
  input  logic                              m_tready_i,
  // child_node, found_group_start, found_group_count, pad
  input  logic [sctw_pkg::OUT_TDATA_W-1:0]  m_tdata_i,
  // status
  input  logic [sctw_pkg::STATUS_W-1:0]     m_tuser_i,
  input  logic                              drain_done_i,
  output int unsigned                       err_count_o
);
  import sctw_pkg::*;

  localparam int NODES = NODES_DEF;

  logic [CODE_W-1:0]   code_mem   [NODES];
  logic [IDX_W-1:0]    next_mem   [NODES];
  logic [IDX_W-1:0]    child_mem  [NODES];
  logic [GSTART_W-1:0] gstart_mem [NODES];
  logic [GCOUNT_W-1:0] gcount_mem [NODES];
  logic [CNT_W-1:0]    node_count_q;
  result_t             expected_results [$];

  initial err_count_o = 0;

  task automatic report(input string msg);
    if (err_count_o < 40) $display("MISMATCH: %s", msg);
    err_count_o++;
  endtask

  // Follow the sibling chain from start until the code matches or the walk stops.
  function automatic result_t predict_lookup(input logic [IDX_W-1:0] start,
                                             input logic [CODE_W-1:0] want);
    result_t     res;
    int          i;
    int unsigned steps;
    res.status            = ST_MISS;
    res.child_node        = IDX_NONE;
    res.found_group_start = '0;
    res.found_group_count = RCOUNT_NONE;
    i     = int'($signed(start));
    steps = 0;
    while (i >= 0 && i < int'(node_count_q) && steps < NODES) begin
      steps++;
      if (code_mem[i] == want) begin
        res.status            = ST_FOUND;
        res.child_node        = child_mem[i];
        res.found_group_start = gstart_mem[i];
        res.found_group_count = {1'b0, gcount_mem[i]};
        return res;
      end
      i = int'($signed(next_mem[i]));
    end
    // -1 ends the chain; anything else that stopped the walk is an overrun
    if (i != -1) res.status = ST_OVERRUN;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    logic [IDX_W-1:0]  idx;
    logic [CODE_W-1:0] code;
    result_t           exp_res;
    if (!rst_ni) begin
      node_count_q = '0;
      expected_results.delete();
    end else begin
      if (cfg_we_i) node_count_q = cfg_wdata_i;

      if (m_tvalid_i && m_tready_i) begin
        if (expected_results.size() == 0) begin
          report($sformatf("result transaction with nothing expected (status %0d)", m_tuser_i));
        end else begin
          exp_res = expected_results.pop_front();
          if (m_tuser_i != exp_res.status)
            report($sformatf("status got %0d expected %0d", m_tuser_i, exp_res.status));
          if (m_tdata_i[12:0] != exp_res.child_node)
            report($sformatf("child_node got %h expected %h",
                             m_tdata_i[12:0], exp_res.child_node));
          if (m_tdata_i[28:13] != exp_res.found_group_start)
            report($sformatf("found_group_start got %h expected %h",
                             m_tdata_i[28:13], exp_res.found_group_start));
          if (m_tdata_i[45:29] != exp_res.found_group_count)
            report($sformatf("found_group_count got %h expected %h",
                             m_tdata_i[45:29], exp_res.found_group_count));
        end
      end

      if (s_tvalid_i && s_tready_i) begin
        idx  = s_tdata_i[12:0];
        code = s_tdata_i[28:13];
        if (kind_e'(s_tuser_i) == KIND_WRITE) begin
          // drop writes to negative indices
          if (!idx[IDX_W-1]) begin
            code_mem[idx]   = code;
            next_mem[idx]   = s_tdata_i[41:29];
            child_mem[idx]  = s_tdata_i[54:42];
            gstart_mem[idx] = s_tdata_i[70:55];
            gcount_mem[idx] = s_tdata_i[86:71];
          end
        end else begin
          expected_results.push_back(predict_lookup(idx, code));
        end
      end
    end
  end

  always @(posedge drain_done_i) begin
    if (expected_results.size() != 0)
      report($sformatf("%0d expected results never arrived", expected_results.size()));
  end

endmodule

// ----- verif/tb_sibling_chain_trie_walk_unit.sv -----
// Testbench top for the trie walk unit: clock, reset, stimulus, back-pressure and verdict.
module tb_sibling_chain_trie_walk_unit;
  import sctw_pkg::*;

  localparam int          NODES            = NODES_DEF;
  localparam int unsigned DRAIN_CYCLES     = 8;
  localparam int unsigned WATCHDOG_LIMIT   = 40000;
  localparam int unsigned LONG_HOLD_AT     = 120;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS      = 140;
  localparam int unsigned MAX_WALK         = 64;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CNT_W-1:0]       cfg_wdata;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]    m_axis_tuser;
  logic                   drain_done;
  int unsigned            chk_errors;

  // Stimulus-side view of the table: keeps lookups on written entries and picks stored codes
  bit                     written_m [NODES];
  logic [CODE_W-1:0]      code_m    [NODES];
  logic [IDX_W-1:0]       next_m    [NODES];
  logic [CNT_W-1:0]       cur_count;

  int unsigned writes_sent, lookups_sent, results_got, settings_n;
  int unsigned found_n, miss_n, overrun_n;
  bit          burst_tx, burst_rx;

  sibling_chain_trie_walk_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  trie_walk_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tuser_i    (m_axis_tuser),
    .drain_done_i (drain_done),
    .err_count_o  (chk_errors)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Length of the walk from start, or -1 if it would read an entry never written.
  function automatic int walk_len(input logic [IDX_W-1:0] start, input logic [CODE_W-1:0] want);
    int i;
    int steps;
    i     = int'($signed(start));
    steps = 0;
    while (i >= 0 && i < int'(cur_count) && steps < NODES) begin
      if (!written_m[i]) return -1;
      steps++;
      if (code_m[i] == want) return steps;
      i = int'($signed(next_m[i]));
    end
    return steps;
  endfunction

  task automatic send_item(input kind_e kind, input logic [IDX_W-1:0] idx,
                           input logic [CODE_W-1:0] code, input logic [IDX_W-1:0] nxt,
                           input logic [IDX_W-1:0] child, input logic [GSTART_W-1:0] gs,
                           input logic [GCOUNT_W-1:0] gc);
    int unsigned gap;
    gap = burst_tx ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {1'b0, gc, gs, child, nxt, code, idx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (kind == KIND_LOOKUP) begin
      lookups_sent++;
    end else begin
      writes_sent++;
      if (!idx[IDX_W-1]) begin
        written_m[idx] = 1'b1;
        code_m[idx]    = code;
        next_m[idx]    = nxt;
      end
    end
  endtask

  task automatic put_node(input logic [IDX_W-1:0] idx, input logic [CODE_W-1:0] code,
                          input logic [IDX_W-1:0] nxt, input logic [IDX_W-1:0] child,
                          input logic [GSTART_W-1:0] gs, input logic [GCOUNT_W-1:0] gc);
    send_item(KIND_WRITE, idx, code, nxt, child, gs, gc);
  endtask

  task automatic find(input logic [IDX_W-1:0] idx, input logic [CODE_W-1:0] code);
    send_item(KIND_LOOKUP, idx, code, 13'($urandom), 13'($urandom), 16'($urandom),
              16'($urandom));
  endtask

  // Hold the sender until every lookup has answered and the block is quiet.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (results_got != lookups_sent) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CNT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    cur_count  = value;
    settings_n++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [CNT_W-1:0] count);
    int unsigned       region, fill, k, r, j, tries;
    logic [IDX_W-1:0]  idx, nxt;
    logic [CODE_W-1:0] code;
    int                len;
    settle();
    write_cfg(count);
    region = (count == 0) ? 16 : ((count < 64) ? int'(count) : 64);
    fill   = (region < 24) ? region : 24;
    for (k = 0; k < PHASE_ITEMS; k++) begin
      if (k % 40 == 0) burst_tx = ($urandom_range(0, 3) == 0);
      if (k < fill || $urandom_range(0, 99) < 35) begin
        r = $urandom_range(0, 99);
        if (r < 85)      idx = 13'($urandom_range(0, region - 1));
        else if (r < 92) idx = 13'($urandom_range(0, NODES - 1));
        else             idx = 13'(8192 - $urandom_range(1, 4096));
        code = ($urandom_range(0, 99) < 70) ? 16'(16'h1111 * $urandom_range(0, 15))
                                            : 16'($urandom);
        r = $urandom_range(0, 99);
        if (r < 55)      nxt = 13'($urandom_range(0, region - 1));
        else if (r < 75) nxt = IDX_NONE;
        else if (r < 85) nxt = 13'(8192 - $urandom_range(2, 4096));
        else             nxt = 13'($urandom);
        put_node(idx, code, nxt, 13'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        len   = -1;
        tries = 0;
        while ((len < 0 || len > MAX_WALK) && tries < 8) begin
          r = $urandom_range(0, 99);
          if (r < 75)      idx = 13'($urandom_range(0, region - 1));
          else if (r < 83) idx = IDX_NONE;
          else if (r < 90) idx = 13'(8192 - $urandom_range(2, 4096));
          else             idx = 13'($urandom);
          r = $urandom_range(0, 99);
          j = $urandom_range(0, region - 1);
          if (r < 60 && written_m[j]) code = code_m[j];
          else if (r < 85)            code = 16'(16'h1111 * $urandom_range(0, 15));
          else                        code = 16'($urandom);
          len = walk_len(idx, code);
          tries++;
        end
        // fall back to an empty start if no safe short walk was drawn
        if (len < 0 || len > MAX_WALK) idx = IDX_NONE;
        find(idx, code);
      end
    end
  endtask

  // Receiver: random stalls per result, one long hold-off to back up the block.
  initial begin
    int unsigned hold;
    hold = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) begin
        results_got++;
        case (status_e'(m_axis_tuser))
          ST_FOUND: found_n++;
          ST_MISS:  miss_n++;
          default:  overrun_n++;
        endcase
        if (results_got % 40 == 0) burst_rx = ($urandom_range(0, 3) == 0);
        if (results_got == LONG_HOLD_AT) hold = LONG_HOLD_CYCLES;
        else hold = burst_rx ? 0 : $urandom_range(0, 10);
      end
      if (hold != 0) begin
        m_axis_tready <= 1'b0;
        hold--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle = 0;
      else idle++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= KIND_WRITE;
    drain_done    <= 1'b0;
    cur_count      = '0;
    burst_tx       = 1'b0;
    burst_rx       = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // node_count still at its reset value of zero
    find(IDX_NONE, 16'h0000);
    find(13'd0, 16'h0000);
    put_node(IDX_NONE, 16'h1111, 13'd1, 13'd1, 16'h1, 16'h1);
    put_node(13'h1000, 16'h2222, 13'd1, 13'd1, 16'h1, 16'h1);
    put_node(13'd4095, 16'hAAAA, 13'd3, 13'h0FFF, 16'h8000, 16'h7FFF);

    settle();
    write_cfg(13'h1000);
    put_node(13'd0, 16'h0000, 13'd1, 13'h0FFF, 16'hFFFF, 16'hFFFF);
    put_node(13'd1, 16'hFFFF, IDX_NONE, IDX_NONE, 16'h0000, 16'h0000);
    put_node(13'd2, 16'h1234, 13'h1FFE, 13'd5, 16'h0001, 16'h0001);
    put_node(13'd3, 16'h5555, 13'd4095, 13'd0, 16'h0002, 16'h0002);
    find(13'd0, 16'h0000);
    find(13'd0, 16'hFFFF);
    find(13'd0, 16'h7777);
    // stored link that is negative but not the chain end
    find(13'd2, 16'h0001);
    find(13'h1FFE, 16'h0000);
    find(13'h1000, 16'h0000);
    find(13'd3, 16'hAAAA);
    // 3 and 4095 link to each other: walk runs out of steps
    find(13'd3, 16'h0BAD);
    find(13'd4095, 16'h5555);

    settle();
    write_cfg(13'd2);
    find(13'd3, 16'h5555);
    find(13'd0, 16'hFFFF);
    find(13'd1, 16'h0BAD);
    put_node(13'd4000, 16'h4242, IDX_NONE, 13'd7, 16'h0009, 16'h000A);
    settle();
    write_cfg(13'h1000);
    find(13'd4000, 16'h4242);

    run_phase(13'd64);
    run_phase(13'd1);
    run_phase(13'h1000);
    run_phase(13'd0);
    run_phase(13'($urandom_range(2, 63)));
    run_phase(13'($urandom_range(65, 4095)));
    run_phase(13'h1000);

    settle();
    drain_done <= 1'b1;
    @(posedge clk);
    @(posedge clk);
    $display("Covered %0d node writes and %0d lookups across %0d node_count settings",
             writes_sent, lookups_sent, settings_n);
    $display("Lookup outcomes: %0d found, %0d not found, %0d overrun",
             found_n, miss_n, overrun_n);
    if (chk_errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
